// File: rtl/cec_pkg.sv
// Shared types, constants and helpers for the echo newline collapser.
package cec_pkg;

	localparam int BYTE_W  = 8;
	localparam int CNT_W   = 16;
	localparam int MAX_RES = 4;
	localparam int SLOT_W  = $clog2(MAX_RES);
	localparam int QDEPTH  = 4;
	localparam int PTR_W   = $clog2(QDEPTH);
	localparam int LEVEL_W = $clog2(QDEPTH + 1);

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam byte_t NL       = 8'h0A;
	localparam byte_t PRINT_LO = 8'h20;
	localparam byte_t PRINT_HI = 8'h7E;

	typedef struct packed {
		byte_t ch;
		cnt_t  cnt;
	} slot_t;

	// All results caused by one item, in emit order.
	typedef struct packed {
		logic [SLOT_W:0]          n;
		logic                     last;
		slot_t [MAX_RES-1:0]      slots;
	} bundle_t;

	typedef struct packed {
		logic               full;
		logic               empty;
		logic [LEVEL_W-1:0] level;
	} qstat_t;

	function automatic logic is_printable(byte_t b);
		return (b >= PRINT_LO) && (b <= PRINT_HI);
	endfunction

	function automatic bundle_t add_slot(bundle_t b, byte_t ch, cnt_t cnt);
		bundle_t r;
		r = b;
		if (r.n < (SLOT_W+1)'(MAX_RES)) begin
			r.slots[r.n[SLOT_W-1:0]].ch  = ch;
			r.slots[r.n[SLOT_W-1:0]].cnt = cnt;
			r.n = r.n + (SLOT_W+1)'(1);
		end
		return r;
	endfunction

endpackage

// File: rtl/cec_in_if.sv
// Input byte channel: valid/ready handshake with byte and frame end flag.
interface cec_in_if;
	logic           valid;
	logic           ready;
	cec_pkg::byte_t in_byte;
	logic           frame_end;

	modport source (output valid, output in_byte, output frame_end, input ready);
	modport sink (input valid, input in_byte, input frame_end, output ready);
endinterface

// File: rtl/cec_out_if.sv
// Result channel: valid/ready handshake with byte, repeat count and frame last flag.
interface cec_out_if;
	logic           valid;
	logic           ready;
	cec_pkg::byte_t out_byte;
	cec_pkg::cnt_t  repeat_count;
	logic           frame_last;

	modport source (output valid, output out_byte, output repeat_count, output frame_last,
		input ready);
	modport sink (input valid, input out_byte, input repeat_count, input frame_last,
		output ready);
endinterface

// File: rtl/char_echo_newline_collapser.sv
// Top level of the echo newline collapser: front end, bundle queue, back end.
//
//   channel    | dir | payload                                  | accepted when
//   -----------+-----+------------------------------------------+---------------------
//   byte_ch    | in  | in_byte[7:0], frame_end                  | valid && ready
//   result_ch  | out | out_byte[7:0], repeat_count[15:0], frame_last | valid && ready
//
// One input item per cycle while the 4-entry bundle queue has room; an item's
// results (0 to 4) are built in the same cycle and queued as one bundle.
// The back end emits one result per cycle while the receiver is ready, so an item's results leave one by one.
// Results pass through the queue and then the output register on their way out.
// Reset empties the queue and returns the collapse state to idle; no clearing pass.
module char_echo_newline_collapser #(
	parameter int MAX_FRAME = 65536
) (
	input logic        clk,
	input logic        arst_n,
	cec_in_if.sink     byte_ch,
	cec_out_if.source  result_ch
);
	import cec_pkg::*;

	logic    push;
	logic    pop;
	bundle_t wr_bundle;
	bundle_t head;
	qstat_t  qstat;

	cec_front #(
		.MAX_FRAME(MAX_FRAME)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_ch (byte_ch),
		.qstat   (qstat),
		.push    (push),
		.bundle  (wr_bundle)
	);

	cec_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_bundle),
		.pop     (pop),
		.rd_data (head),
		.stat    (qstat)
	);

	cec_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.result_ch (result_ch)
	);

`ifndef SYNTH
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qstat.level <= LEVEL_W'(QDEPTH))
		else $error("bundle queue level out of range");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_ch.valid |-> (result_ch.repeat_count != '0))
		else $error("result with zero repeat count");

	a_repeat_newline: assert property (@(posedge clk) disable iff (!arst_n)
		(result_ch.valid && (result_ch.repeat_count != cnt_t'(1))) |->
		(result_ch.out_byte == NL))
		else $error("repeated result that is not a newline");

	a_no_empty_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (wr_bundle.n != '0))
		else $error("empty bundle queued");
`endif

endmodule

// File: rtl/cec_front.sv
// Front end: accepts bytes, runs the collapse state machine, builds result bundles.
module cec_front #(
	parameter int MAX_FRAME = 65536
) (
	input  logic             clk,
	input  logic             arst_n,
	cec_in_if.sink           byte_ch,
	input  cec_pkg::qstat_t  qstat,
	output logic             push,
	output cec_pkg::bundle_t bundle
);
	import cec_pkg::*;

	localparam int   RUN_CAP_I = (MAX_FRAME - 1 < 65535) ? (MAX_FRAME - 1) : 65535;
	localparam cnt_t RUN_CAP   = CNT_W'(RUN_CAP_I);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_HELD,
		PH_RUN,
		PH_CAND
	} phase_t;

	phase_t  phase_q, phase_d;
	byte_t   held_q, held_d;
	byte_t   cand_q, cand_d;
	cnt_t    run_q, run_d;
	bundle_t nb;
	logic    accept;
	logic    pr;
	logic    nl;
	logic    go_idle;
	byte_t   b;

	assign byte_ch.ready = !qstat.full;
	assign accept        = byte_ch.valid && byte_ch.ready;

	always_comb begin
		b       = byte_ch.in_byte;
		pr      = is_printable(b);
		nl      = (b == NL);
		nb      = '0;
		go_idle = 1'b0;
		phase_d = phase_q;
		held_d  = held_q;
		cand_d  = cand_q;
		run_d   = run_q;

		unique case (phase_q)
			PH_IDLE: begin
				go_idle = 1'b1;
			end
			PH_HELD: begin
				if (nl) begin
					run_d   = cnt_t'(1);
					phase_d = PH_RUN;
				end else begin
					nb      = add_slot(nb, held_q, cnt_t'(1));
					go_idle = 1'b1;
				end
			end
			PH_RUN: begin
				if (nl) begin
					if (run_q < RUN_CAP)
						run_d = run_q + cnt_t'(1);
				end else if (pr) begin
					cand_d  = b;
					phase_d = PH_CAND;
				end else begin
					nb      = add_slot(nb, held_q, cnt_t'(1));
					nb      = add_slot(nb, NL, run_q);
					nb      = add_slot(nb, b, cnt_t'(1));
					run_d   = '0;
					phase_d = PH_IDLE;
				end
			end
			PH_CAND: begin
				if (nl) begin
					// collapse: drop the run, candidate takes the held slot
					nb      = add_slot(nb, held_q, cnt_t'(1));
					held_d  = cand_q;
					run_d   = cnt_t'(1);
					phase_d = PH_RUN;
				end else begin
					nb      = add_slot(nb, held_q, cnt_t'(1));
					nb      = add_slot(nb, NL, run_q);
					nb      = add_slot(nb, cand_q, cnt_t'(1));
					run_d   = '0;
					go_idle = 1'b1;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		if (go_idle) begin
			if (pr) begin
				held_d  = b;
				run_d   = '0;
				phase_d = PH_HELD;
			end else begin
				nb      = add_slot(nb, b, cnt_t'(1));
				phase_d = PH_IDLE;
			end
		end

		// frame end flushes whatever is still held
		if (byte_ch.frame_end) begin
			unique case (phase_d)
				PH_HELD: begin
					nb = add_slot(nb, held_d, cnt_t'(1));
				end
				PH_RUN: begin
					nb = add_slot(nb, held_d, cnt_t'(1));
					nb = add_slot(nb, NL, run_d);
				end
				PH_CAND: begin
					nb = add_slot(nb, held_d, cnt_t'(1));
					nb = add_slot(nb, NL, run_d);
					nb = add_slot(nb, cand_d, cnt_t'(1));
				end
				default: begin
				end
			endcase
			nb.last = 1'b1;
			phase_d = PH_IDLE;
			held_d  = '0;
			cand_d  = '0;
			run_d   = '0;
		end
	end

	assign push   = accept && (nb.n != '0);
	assign bundle = nb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
			cand_q  <= '0;
			run_q   <= '0;
		end else if (accept) begin
			phase_q <= phase_d;
			held_q  <= held_d;
			cand_q  <= cand_d;
			run_q   <= run_d;
		end
	end

endmodule

// File: rtl/cec_queue.sv
// Short bundle queue between the front end and the back end.
module cec_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  cec_pkg::bundle_t wr_data,
	input  logic             pop,
	output cec_pkg::bundle_t rd_data,
	output cec_pkg::qstat_t  stat
);
	import cec_pkg::*;

	bundle_t            mem [QDEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [LEVEL_W-1:0] level_q;
	logic               do_push;
	logic               do_pop;

	assign stat.full  = (level_q == LEVEL_W'(QDEPTH));
	assign stat.empty = (level_q == '0);
	assign stat.level = level_q;
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign rd_data    = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			unique case ({do_push, do_pop})
				2'b10:   level_q <= level_q + LEVEL_W'(1);
				2'b01:   level_q <= level_q - LEVEL_W'(1);
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

// File: rtl/cec_back.sv
// Back end: walks the head bundle into the output register, one result per cycle unless the output is stalled.
module cec_back (
	input  logic             clk,
	input  logic             arst_n,
	input  cec_pkg::bundle_t head,
	input  cec_pkg::qstat_t  qstat,
	output logic             pop,
	cec_out_if.source        result_ch
);
	import cec_pkg::*;

	logic              valid_q;
	logic [SLOT_W-1:0] idx_q;
	byte_t             byte_q;
	cnt_t              cnt_q;
	logic              last_q;
	logic              adv;
	logic              take;
	logic              at_end;

	assign adv    = !valid_q || result_ch.ready;
	assign take   = adv && !qstat.empty;
	assign at_end = ({1'b0, idx_q} == head.n - (SLOT_W+1)'(1));
	assign pop    = take && at_end;

	assign result_ch.valid        = valid_q;
	assign result_ch.out_byte     = byte_q;
	assign result_ch.repeat_count = cnt_q;
	assign result_ch.frame_last   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (adv) begin
			valid_q <= !qstat.empty;
			if (take)
				idx_q <= at_end ? '0 : idx_q + SLOT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_q <= head.slots[idx_q].ch;
			cnt_q  <= head.slots[idx_q].cnt;
			last_q <= head.last && at_end;
		end
	end

endmodule

// File: tb/sv/char_echo_newline_collapser_test.sv
// Self-checking testbench for the echo newline collapser.
`timescale 1ns / 1ps

module char_echo_newline_collapser_test;
	import cec_pkg::*;

	localparam int FRAME_MAX = 65536;
	localparam int unsigned RUN_LIMIT = (FRAME_MAX - 1 < 65535) ? FRAME_MAX - 1 : 65535;
	localparam int LONG_HOLD = 300;
	localparam int LONG_RUN = 9;
	localparam byte_t EDGE_BYTES [4] = '{8'h1F, 8'h20, 8'h7E, 8'h7F};

	typedef enum logic [1:0] {ST_IDLE, ST_HELD, ST_RUN, ST_CAND} collapse_state_t;

	typedef struct {
		byte_t b;
		logic  fin;
	} echo_byte_t;

	typedef struct {
		byte_t ch;
		cnt_t  cnt;
		logic  last;
	} echo_result_t;

	logic clk = 1'b0;
	logic arst_n;

	cec_in_if  byte_ch ();
	cec_out_if result_ch ();

	char_echo_newline_collapser #(.MAX_FRAME(FRAME_MAX)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.result_ch (result_ch)
	);

	always #2 clk = ~clk;

	echo_byte_t   byte_feed [$];
	echo_result_t expected_out [$];
	echo_result_t step_out [$];

	// collapse state tracked by the predictor
	collapse_state_t col_state = ST_IDLE;
	byte_t           kept_char = '0;
	byte_t           next_char = '0;
	int unsigned     nl_count = 0;

	logic        calm = 1'b0;
	logic        want_long_stall = 1'b0;
	logic        long_stall_done;
	int          stall_left;
	int unsigned items_in = 0;
	int unsigned frames_in = 0;
	int unsigned results_seen = 0;
	int unsigned fails = 0;

	function automatic logic is_text(byte_t b);
		return b >= PRINT_LO && b <= PRINT_HI;
	endfunction

	task automatic emit(byte_t ch, int unsigned cnt);
		if (cnt != 0 && step_out.size() < MAX_RES)
			step_out.push_back('{ch: ch, cnt: cnt_t'(cnt), last: 1'b0});
	endtask

	task automatic take_fresh(byte_t b);
		if (is_text(b)) begin
			kept_char = b;
			nl_count = 0;
			col_state = ST_HELD;
		end else begin
			emit(b, 1);
			col_state = ST_IDLE;
		end
	endtask

	// Works out the results of one accepted byte and queues them.
	task automatic collapse_step(byte_t b, logic fin);
		step_out.delete();
		case (col_state)
			ST_IDLE: take_fresh(b);
			ST_HELD: begin
				if (b == NL) begin
					nl_count = 1;
					col_state = ST_RUN;
				end else begin
					emit(kept_char, 1);
					take_fresh(b);
				end
			end
			ST_RUN: begin
				if (b == NL) begin
					if (nl_count < RUN_LIMIT)
						nl_count++;
				end else if (is_text(b)) begin
					next_char = b;
					col_state = ST_CAND;
				end else begin
					emit(kept_char, 1);
					emit(NL, nl_count);
					emit(b, 1);
					nl_count = 0;
					col_state = ST_IDLE;
				end
			end
			ST_CAND: begin
				if (b == NL) begin
					// run dropped, candidate takes over as the held byte
					emit(kept_char, 1);
					kept_char = next_char;
					nl_count = 1;
					col_state = ST_RUN;
				end else begin
					emit(kept_char, 1);
					emit(NL, nl_count);
					emit(next_char, 1);
					nl_count = 0;
					take_fresh(b);
				end
			end
		endcase
		if (fin) begin
			if (col_state != ST_IDLE)
				emit(kept_char, 1);
			if (col_state == ST_RUN || col_state == ST_CAND)
				emit(NL, nl_count);
			if (col_state == ST_CAND)
				emit(next_char, 1);
			col_state = ST_IDLE;
			kept_char = '0;
			next_char = '0;
			nl_count = 0;
			if (step_out.size() != 0)
				step_out[step_out.size() - 1].last = 1'b1;
		end
		foreach (step_out[i])
			expected_out.push_back(step_out[i]);
	endtask

	task automatic push_byte(byte_t b, logic fin);
		byte_feed.push_back('{b: b, fin: fin});
	endtask

	// Frames mostly of text, newline runs and collapse patterns, with some noise.
	task automatic queue_random_frames(int unsigned n);
		byte_t       frame [$];
		int unsigned made;
		int unsigned len;
		int unsigned pick;
		made = 0;
		while (made < n) begin
			frame.delete();
			len = $urandom_range(1, 12);
			while (frame.size() < len) begin
				pick = $urandom_range(0, 15);
				if (pick <= 5)
					frame.push_back(byte_t'($urandom_range(8'h20, 8'h7E)));
				else if (pick <= 9)
					repeat ($urandom_range(1, 3)) frame.push_back(NL);
				else if (pick <= 11) begin
					frame.push_back(byte_t'($urandom_range(8'h20, 8'h7E)));
					frame.push_back(NL);
				end else if (pick == 12)
					frame.push_back(byte_t'($urandom_range(0, 8'h1F)));
				else if (pick == 13)
					frame.push_back(byte_t'($urandom_range(8'h7F, 8'hFF)));
				else if (pick == 14)
					frame.push_back(byte_t'($urandom_range(0, 255)));
				else
					frame.push_back(EDGE_BYTES[$urandom_range(0, 3)]);
			end
			foreach (frame[k])
				push_byte(frame[k], k == frame.size() - 1);
			made += frame.size();
		end
	endtask

	task automatic wait_fed();
		while (byte_feed.size() != 0)
			@(negedge clk);
	endtask

	task automatic drain();
		while (byte_feed.size() != 0 || byte_ch.valid || expected_out.size() != 0)
			@(negedge clk);
	endtask

	// Byte sender
	always @(posedge clk or negedge arst_n) begin : feed_bytes
		echo_byte_t nxt;
		if (!arst_n) begin
			byte_ch.valid <= 1'b0;
			byte_ch.in_byte <= '0;
			byte_ch.frame_end <= 1'b0;
		end else begin
			if (byte_ch.valid && byte_ch.ready) begin
				collapse_step(byte_ch.in_byte, byte_ch.frame_end);
				items_in <= items_in + 1;
				if (byte_ch.frame_end)
					frames_in <= frames_in + 1;
			end
			if (!byte_ch.valid || byte_ch.ready) begin
				if (byte_feed.size() != 0 && (calm || $urandom_range(0, 99) >= 7)) begin
					nxt = byte_feed.pop_front();
					byte_ch.valid <= 1'b1;
					byte_ch.in_byte <= nxt.b;
					byte_ch.frame_end <= nxt.fin;
				end else begin
					byte_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver, with one long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			stall_left <= 0;
			long_stall_done <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			result_ch.ready <= 1'b0;
		end else if (want_long_stall && !long_stall_done) begin
			long_stall_done <= 1'b1;
			stall_left <= LONG_HOLD - 1;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= calm || $urandom_range(0, 99) >= 7;
		end
	end

	always @(posedge clk) begin : check_results
		echo_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			results_seen <= results_seen + 1;
			if (expected_out.size() == 0) begin
				$error("unexpected result: out_byte %h repeat_count %0d frame_last %b",
					result_ch.out_byte, result_ch.repeat_count, result_ch.frame_last);
				fails <= fails + 1;
			end else begin
				want = expected_out.pop_front();
				if (result_ch.out_byte !== want.ch) begin
					$error("out_byte: expected %h, got %h", want.ch, result_ch.out_byte);
					fails <= fails + 1;
				end
				if (result_ch.repeat_count !== want.cnt) begin
					$error("repeat_count: expected %0d, got %0d", want.cnt,
						result_ch.repeat_count);
					fails <= fails + 1;
				end
				if (result_ch.frame_last !== want.last) begin
					$error("frame_last: expected %b, got %b", want.last, result_ch.frame_last);
					fails <= fails + 1;
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		byte_ch.valid = 1'b0;
		byte_ch.in_byte = '0;
		byte_ch.frame_end = 1'b0;
		result_ch.ready = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// collapse with the closing newline on the frame edge
		push_byte("A", 1'b0);
		push_byte(NL, 1'b0);
		push_byte(NL, 1'b0);
		push_byte("B", 1'b0);
		push_byte(NL, 1'b1);
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		// candidate broken by a non-printable: four results
		push_byte(8'h20, 1'b0);
		push_byte(NL, 1'b0);
		push_byte(8'h7E, 1'b0);
		push_byte(8'h7F, 1'b1);
		// candidate broken by a printable, which is then held and flushed at the end
		push_byte(8'h7E, 1'b0);
		push_byte(NL, 1'b0);
		push_byte(8'h20, 1'b0);
		push_byte("x", 1'b1);
		push_byte(NL, 1'b1);
		push_byte("q", 1'b0);
		push_byte(NL, 1'b1);
		push_byte("p", 1'b1);
		push_byte(8'h1F, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte("k", 1'b1);
		push_byte("m", 1'b0);
		push_byte("n", 1'b1);
		drain();

		// long newline run released by a control byte
		push_byte("Z", 1'b0);
		repeat (LONG_RUN) push_byte(NL, 1'b0);
		push_byte(8'h01, 1'b1);
		drain();

		want_long_stall = 1'b1;
		queue_random_frames(35);
		wait_fed();
		calm = 1'b1;
		queue_random_frames(30);
		wait_fed();
		calm = 1'b0;
		queue_random_frames(30);
		drain();
		repeat (20) @(negedge clk);

		$display("Sent %0d bytes in %0d frames and checked %0d results,",
			items_in, frames_in, results_seen);
		$display("with a %0d-newline run and a %0d-cycle output hold-off.",
			LONG_RUN, LONG_HOLD);
		if (fails == 0 && expected_out.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d results outstanding", expected_out.size());
		$display("*** FAILED ***");
		$finish;
	end

endmodule
